// ===== rtl/rxabc_pkg.sv =====
// ----------------------------------------------------------------------------
// rxabc_pkg
// shared types, constants and rotate helpers for the rotate-xor-add cipher
// ----------------------------------------------------------------------------
package rxabc_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 64;
    localparam int ROT_W   = 6;

    localparam logic [KEY_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    // register select is paddr[3]: key_low at 0x0, key_high at 0x8
    localparam logic REG_SEL_KEY_LOW  = 1'b0;
    localparam logic REG_SEL_KEY_HIGH = 1'b1;

    typedef struct packed
    {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    function automatic logic [BLOCK_W-1:0] rotl64(input logic [BLOCK_W-1:0] v,
                                                  input logic [ROT_W-1:0] n);
        logic [2*BLOCK_W-1:0] w;
        w = {v, v} << n;
        return w[2*BLOCK_W-1:BLOCK_W];
    endfunction

    function automatic logic [BLOCK_W-1:0] rotr64(input logic [BLOCK_W-1:0] v,
                                                  input logic [ROT_W-1:0] n);
        logic [2*BLOCK_W-1:0] w;
        w = {v, v} >> n;
        return w[BLOCK_W-1:0];
    endfunction

endpackage

// ===== rtl/rxabc_round.sv =====
// ----------------------------------------------------------------------------
// rxabc_round
// one registered cipher round, encrypt or decrypt per transaction
// ----------------------------------------------------------------------------
module rxabc_round
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rxabc_pkg::stage_ctl_t             ctl_in,
    input  logic [rxabc_pkg::BLOCK_W-1:0]     data_in,
    input  logic [rxabc_pkg::KEY_W-1:0]       round_key,
    output rxabc_pkg::stage_ctl_t             ctl_out,
    output logic [rxabc_pkg::BLOCK_W-1:0]     data_out
);

    rxabc_pkg::stage_ctl_t             ctl_reg;
    logic [rxabc_pkg::BLOCK_W-1:0]     data_reg;
    logic [rxabc_pkg::BLOCK_W-1:0]     data_next;
    logic [rxabc_pkg::BLOCK_W-1:0]     enc_val;
    logic [rxabc_pkg::BLOCK_W-1:0]     dec_val;
    logic [rxabc_pkg::ROT_W-1:0]       rot_amt;

    always_comb
    begin
        rot_amt   = round_key[rxabc_pkg::ROT_W-1:0];
        enc_val   = rxabc_pkg::rotl64(data_in ^ round_key, rot_amt) + round_key;
        dec_val   = rxabc_pkg::rotr64(data_in - round_key, rot_amt) ^ round_key;
        data_next = ctl_in.decrypt ? dec_val : enc_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

// ===== rtl/rotate_xor_add_block_cipher.sv =====
// ----------------------------------------------------------------------------
// rotate_xor_add_block_cipher
// 64-bit rotate-xor-add block cipher, one round per pipeline stage
// ----------------------------------------------------------------------------
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+----------------------
// command   | start, busy, cmd, block_in                | start & !busy
// result    | done, block_out                           | done, one cycle
// config    | psel, penable, pwrite, paddr, pwdata,     | apb write, pready = 1
//           | prdata, pready                            |
//
// a transaction enters every cycle while busy is low, and its result strobes on
// done after the input register and one register stage per round
// a key write recomputes the round key schedule, one key per cycle, so busy
// stays high after the write until the last round key is written
// reset clears both key registers and all round keys, so blocks pass through
// unchanged until a key is written
// the result side never stalls, so the pipeline never holds
// ----------------------------------------------------------------------------
module rotate_xor_add_block_cipher
#(
    parameter int ROUND_COUNT = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [rxabc_pkg::BLOCK_W-1:0]     block_in,
    output logic                              done,
    output logic [rxabc_pkg::BLOCK_W-1:0]     block_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [rxabc_pkg::KEY_W-1:0]       pwdata,
    output logic [rxabc_pkg::KEY_W-1:0]       prdata,
    output logic                              pready
);

    localparam int IDX_W = $clog2(ROUND_COUNT);

    typedef enum logic [1:0]
    {
        SCHED_IDLE = 2'b01,
        SCHED_RUN  = 2'b10
    } sched_state_t;

    sched_state_t                    state_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [rxabc_pkg::KEY_W-1:0]     key_low_reg;
    logic [rxabc_pkg::KEY_W-1:0]     key_high_reg;
    logic [rxabc_pkg::KEY_W-1:0]     key_low_next;
    logic [rxabc_pkg::KEY_W-1:0]     key_high_next;
    logic [rxabc_pkg::KEY_W-1:0]     prev1_reg;
    logic [rxabc_pkg::KEY_W-1:0]     prev2_reg;
    logic [rxabc_pkg::KEY_W-1:0]     sched_key_next;
    logic [7:0]                      rot_wide;
    logic [rxabc_pkg::KEY_W-1:0]     rk_reg [0:ROUND_COUNT-1];
    logic                            cfg_write;

    rxabc_pkg::stage_ctl_t           ctl_chain  [0:ROUND_COUNT];
    logic [rxabc_pkg::BLOCK_W-1:0]   data_chain [0:ROUND_COUNT];
    logic [rxabc_pkg::KEY_W-1:0]     key_sel    [0:ROUND_COUNT-1];

    rxabc_pkg::stage_ctl_t           s0_ctl_reg;
    logic [rxabc_pkg::BLOCK_W-1:0]   s0_data_reg;

    // apb side
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == rxabc_pkg::REG_SEL_KEY_HIGH) ? key_high_reg : key_low_reg;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_write)
        begin
            if (paddr[3] == rxabc_pkg::REG_SEL_KEY_LOW)
            begin
                key_low_next = pwdata;
            end
            else
            begin
                key_high_next = pwdata;
            end
        end
    end

    // schedule step: (rotl(rk[i-1], 3*i) ^ rk[i-2]) + golden step
    always_comb
    begin
        rot_wide       = 8'(idx_reg) * 8'd3;
        sched_key_next = (rxabc_pkg::rotl64(prev1_reg, rot_wide[rxabc_pkg::ROT_W-1:0])
                          ^ prev2_reg) + rxabc_pkg::GOLDEN_STEP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SCHED_IDLE;
            idx_reg      <= '0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            prev1_reg    <= '0;
            prev2_reg    <= '0;
            for (int i = 0; i < ROUND_COUNT; i++)
            begin
                rk_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            rk_reg[0]    <= key_low_next;
            rk_reg[1]    <= key_high_next;
            prev2_reg    <= key_low_next;
            prev1_reg    <= key_high_next;
            idx_reg      <= IDX_W'(2);
            state_reg    <= (ROUND_COUNT > 2) ? SCHED_RUN : SCHED_IDLE;
        end
        else
        begin
            case (state_reg)
                SCHED_RUN:
                begin
                    rk_reg[idx_reg] <= sched_key_next;
                    prev2_reg       <= prev1_reg;
                    prev1_reg       <= sched_key_next;
                    if (idx_reg == IDX_W'(ROUND_COUNT - 1))
                    begin
                        state_reg <= SCHED_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                SCHED_IDLE:
                begin
                    state_reg <= SCHED_IDLE;
                end
                default:
                begin
                    state_reg <= SCHED_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != SCHED_IDLE);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else
        begin
            s0_ctl_reg.valid   <= start && !busy;
            s0_ctl_reg.decrypt <= (cmd == rxabc_pkg::CMD_DECRYPT);
        end
    end

    always_ff @(posedge clk)
    begin
        s0_data_reg <= block_in;
    end

    assign ctl_chain[0]  = s0_ctl_reg;
    assign data_chain[0] = s0_data_reg;

    // decryption walks the schedule from the last key back
    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        assign key_sel[g] = ctl_chain[g].decrypt ? rk_reg[ROUND_COUNT-1-g] : rk_reg[g];

        rxabc_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_chain[g]),
            .data_in   (data_chain[g]),
            .round_key (key_sel[g]),
            .ctl_out   (ctl_chain[g+1]),
            .data_out  (data_chain[g+1])
        );
    end

    assign done      = ctl_chain[ROUND_COUNT].valid;
    assign block_out = data_chain[ROUND_COUNT];

`ifndef NO_ASSERTIONS
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ROUND_COUNT + 1))
        else $error("result without a transaction accepted at the expected cycle");

    a_sched_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCHED_RUN) |-> (idx_reg >= IDX_W'(2) && idx_reg <= IDX_W'(ROUND_COUNT - 1)))
        else $error("schedule index out of range while running");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (ROUND_COUNT > 2)) |=> busy)
        else $error("key write did not start the schedule");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives encrypt and decrypt transactions into the rotate-xor-add cipher in
// random bursts, writes the key halves over the apb port between phases, and
// checks every output block against an in-bench model of the key schedule
// and the eight rounds
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_ROUNDS    = 8;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int RANDOM_PHASES = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [3:0] ADDR_KEY_LOW  = {rxabc_pkg::REG_SEL_KEY_LOW, 3'b000};
    localparam logic [3:0] ADDR_KEY_HIGH = {rxabc_pkg::REG_SEL_KEY_HIGH, 3'b000};

    typedef struct
    {
        rxabc_pkg::cmd_t               op;
        logic [rxabc_pkg::BLOCK_W-1:0] blk_in;
        logic [rxabc_pkg::BLOCK_W-1:0] blk_out;
    } block_txn_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          start    = 1'b0;
    logic                          busy;
    rxabc_pkg::cmd_t               cmd      = rxabc_pkg::CMD_ENCRYPT;
    logic [rxabc_pkg::BLOCK_W-1:0] block_in = '0;
    logic                          done;
    logic [rxabc_pkg::BLOCK_W-1:0] block_out;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [3:0]                    paddr    = '0;
    logic [rxabc_pkg::KEY_W-1:0]   pwdata   = '0;
    logic [rxabc_pkg::KEY_W-1:0]   prdata;
    logic                          pready;

    block_txn_t                    pending_blocks[$];
    logic [rxabc_pkg::KEY_W-1:0]   key_lo = '0;
    logic [rxabc_pkg::KEY_W-1:0]   key_hi = '0;
    logic [rxabc_pkg::KEY_W-1:0]   round_keys[NUM_ROUNDS];
    logic [rxabc_pkg::BLOCK_W-1:0] recent_cipher[$];
    int                            burst_left     = 0;
    int                            mismatch_count = 0;
    int                            cycle_count    = 0;

    rotate_xor_add_block_cipher
    #(
        .ROUND_COUNT (NUM_ROUNDS)
    )
    u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] spin_left(input logic [63:0] v, input int unsigned n);
        int unsigned s;
        s = n % 64;
        if (s == 0)
            return v;
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] spin_right(input logic [63:0] v, input int unsigned n);
        int unsigned s;
        s = n % 64;
        if (s == 0)
            return v;
        return (v >> s) | (v << (64 - s));
    endfunction

    function automatic void rebuild_round_keys();
        round_keys[0] = key_lo;
        round_keys[1] = key_hi;
        for (int i = 2; i < NUM_ROUNDS; i++)
        begin
            round_keys[i] = (spin_left(round_keys[i-1], (3 * i) % 64) ^ round_keys[i-2])
                            + rxabc_pkg::GOLDEN_STEP;
        end
    endfunction

    function automatic logic [63:0] cipher_block(input rxabc_pkg::cmd_t op,
                                                 input logic [63:0] blk);
        logic [63:0] x;
        logic [63:0] k;
        x = blk;
        if (op == rxabc_pkg::CMD_ENCRYPT)
        begin
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                k = round_keys[r];
                x = spin_left(x ^ k, k[5:0]) + k;
            end
        end
        else
        begin
            for (int r = NUM_ROUNDS - 1; r >= 0; r--)
            begin
                k = round_keys[r];
                x = spin_right(x - k, k[5:0]) ^ k;
            end
        end
        return x;
    endfunction

    // biased toward extremes, single bits and zero rotate amounts
    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = 64'h1 << $urandom_range(0, 63);
            3: w[5:0] = 6'd0;
            default: ;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_block(input rxabc_pkg::cmd_t op, input logic [63:0] blk,
                              output logic [63:0] predicted);
        block_txn_t txn;
        int         gap;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        start    <= 1'b1;
        cmd      <= op;
        block_in <= blk;
        do
            @(posedge clk);
        while (busy);
        txn.op      = op;
        txn.blk_in  = blk;
        txn.blk_out = cipher_block(op, blk);
        pending_blocks.insert(pending_blocks.size(), txn);
        predicted  = txn.blk_out;
        burst_left = burst_left - 1;
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        burst_left = 0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
        drain_pipeline();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KEY_LOW)
            key_lo = value;
        else
            key_hi = value;
        rebuild_round_keys();
    endtask

    // all round keys zero: blocks come back unchanged
    task automatic test_reset_passthrough();
        logic [63:0] patterns[6];
        logic [63:0] unused;
        patterns = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h1,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        foreach (patterns[i])
        begin
            send_block(rxabc_pkg::CMD_ENCRYPT, patterns[i], unused);
            send_block(rxabc_pkg::CMD_DECRYPT, patterns[i], unused);
        end
    endtask

    task automatic test_key_extremes();
        logic [63:0] ct;
        logic [63:0] unused;
        write_key(ADDR_KEY_LOW, '1);
        write_key(ADDR_KEY_HIGH, '0);
        send_block(rxabc_pkg::CMD_ENCRYPT, '0, unused);
        send_block(rxabc_pkg::CMD_DECRYPT, '1, unused);
        // first two round keys with rotate amount zero
        write_key(ADDR_KEY_LOW, 64'h0123_4567_89AB_CDC0);
        write_key(ADDR_KEY_HIGH, 64'hFEDC_BA98_7654_3200);
        send_block(rxabc_pkg::CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF, ct);
        send_block(rxabc_pkg::CMD_DECRYPT, ct, unused);
        send_block(rxabc_pkg::CMD_ENCRYPT, '1, unused);
        send_block(rxabc_pkg::CMD_DECRYPT, '0, unused);
    endtask

    // mostly encrypt then decrypt of a recent ciphertext, plus random noise
    task automatic test_random_traffic();
        logic [63:0] ct;
        int          per_phase;
        int          sel;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_key(ADDR_KEY_LOW, '1);
                    write_key(ADDR_KEY_HIGH, '1);
                end
                1:
                begin
                    write_key(ADDR_KEY_LOW, '0);
                    write_key(ADDR_KEY_HIGH, '0);
                end
                default:
                begin
                    if (p % 3 != 2)
                        write_key(ADDR_KEY_LOW, pick_word());
                    write_key(ADDR_KEY_HIGH, pick_word());
                end
            endcase
            recent_cipher.delete();
            for (int n = 0; n < per_phase; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40 || (sel < 75 && recent_cipher.size() == 0))
                begin
                    send_block(rxabc_pkg::CMD_ENCRYPT, pick_word(), ct);
                    recent_cipher.insert(recent_cipher.size(), ct);
                    if (recent_cipher.size() > 8)
                        void'(recent_cipher.pop_front());
                end
                else if (sel < 75)
                begin
                    send_block(rxabc_pkg::CMD_DECRYPT,
                               recent_cipher[$urandom_range(0, recent_cipher.size() - 1)],
                               ct);
                end
                else
                begin
                    send_block(sel[0] ? rxabc_pkg::CMD_DECRYPT : rxabc_pkg::CMD_ENCRYPT,
                               pick_word(), ct);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        block_txn_t oldest;
        if (rst_n && done)
        begin
            if (pending_blocks.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transaction: block_out %h", block_out);
            end
            else
            begin
                oldest = pending_blocks.pop_front();
                if (block_out !== oldest.blk_out)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("block_out mismatch: %s of %h, expected %h, got %h",
                                 oldest.op.name(), oldest.blk_in, oldest.blk_out, block_out);
                end
            end
        end
    end

    initial
    begin
        // after reset the schedule is all zero, not derived from zero keys
        foreach (round_keys[i])
            round_keys[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_passthrough();
        test_key_extremes();
        test_random_traffic();
        drain_pipeline();
        repeat (NUM_ROUNDS + 4) @(posedge clk);
        if (mismatch_count == 0 && pending_blocks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rxabc_pkg.sv
rtl/rxabc_round.sv
rtl/rotate_xor_add_block_cipher.sv
tb/tb_top.sv
